/* sv/dwc_pkg.sv */
`timescale 1ns / 1ps
// Package for the digitizer word classifier: payload structs, class codes,
// continuation kinds and the two header type tables. No dependencies.
package dwc_pkg;

  localparam int unsigned CountWidthDefault = 32;
  localparam int unsigned NumClasses        = 16;
  localparam int unsigned ClassW            = 4;
  localparam int unsigned WinW              = 12;
  localparam int unsigned OutCountW         = 32;

  typedef enum logic [1:0] {
    PendNone   = 2'd0,
    PendOne    = 2'd1,
    PendPulse  = 2'd2,
    PendWindow = 2'd3
  } pend_e;

  localparam logic [ClassW-1:0] ClsUnknown   = 4'd0;
  localparam logic [ClassW-1:0] ClsBlockHdr  = 4'd1;
  localparam logic [ClassW-1:0] ClsBlockTrl  = 4'd2;
  localparam logic [ClassW-1:0] ClsEventHdr  = 4'd3;
  localparam logic [ClassW-1:0] ClsTrigTime  = 4'd4;
  localparam logic [ClassW-1:0] ClsWindowRaw = 4'd5;
  localparam logic [ClassW-1:0] ClsIntegral  = 4'd6;
  localparam logic [ClassW-1:0] ClsTime      = 4'd7;
  localparam logic [ClassW-1:0] ClsPulseData = 4'd8;
  localparam logic [ClassW-1:0] ClsPedestal  = 4'd9;
  localparam logic [ClassW-1:0] ClsEventTrl  = 4'd10;
  localparam logic [ClassW-1:0] ClsNotValid  = 4'd11;
  localparam logic [ClassW-1:0] ClsFiller    = 4'd12;
  localparam logic [ClassW-1:0] ClsCdc       = 4'd13;
  localparam logic [ClassW-1:0] ClsFdcInt    = 4'd14;
  localparam logic [ClassW-1:0] ClsFdcPeak   = 4'd15;

  typedef struct packed {
    logic [31:0] data_word;
    logic        bank_end;
  } in_t;

  typedef struct packed {
    logic [ClassW-1:0]    word_class;
    logic [OutCountW-1:0] class_count;
  } out_t;

  typedef struct packed {
    pend_e             pend;
    logic [ClassW-1:0] cls;
  } tab_ent_t;

  function automatic tab_ent_t type_lookup(logic f125, logic [3:0] typ);
    tab_ent_t e;
    e.pend = PendNone;
    e.cls  = ClsUnknown;
    case (typ)
      4'd0:  e.cls = ClsBlockHdr;
      4'd1:  e.cls = ClsBlockTrl;
      4'd2:  e.cls = ClsEventHdr;
      4'd3:  begin
        e.cls  = ClsTrigTime;
        e.pend = PendOne;
      end
      4'd4:  e.cls = ClsWindowRaw;
      4'd5:  begin
        if (f125) begin
          e.cls  = ClsCdc;
          e.pend = PendOne;
        end
      end
      4'd6:  begin
        if (f125) begin
          e.cls  = ClsFdcInt;
          e.pend = PendOne;
        end
      end
      4'd7:  e.cls = ClsIntegral;
      4'd8:  e.cls = ClsTime;
      4'd9:  begin
        if (f125) begin
          e.cls  = ClsFdcPeak;
          e.pend = PendOne;
        end else begin
          e.cls  = ClsPulseData;
          e.pend = PendPulse;
        end
      end
      4'd10: e.cls = ClsPedestal;
      4'd13: e.cls = ClsEventTrl;
      4'd14: e.cls = ClsNotValid;
      4'd15: e.cls = ClsFiller;
      default: e.cls = ClsUnknown;
    endcase
    return e;
  endfunction

endpackage

/* sv/dwc_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Read returns the old entry when read and write hit the same address.
module dwc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/digitizer_word_classifier_top.sv */
`timescale 1ns / 1ps
// Digitizer word classifier: decodes bank words and keeps saturating class
// counters in a 16-entry RAM (dwc_ram); uses dwc_pkg.
// Path: RAM read into its read data register, then increment and write back
// into the output register. Throughput: one word per cycle while the output
// is not stalled, set by the single read-modify-write of the counter RAM
// with forwarding of a same-cycle write. Reset clears pending state, module
// kind and the per-entry valid bits, so every counter reads as zero at once.
module digitizer_word_classifier_top #(
  parameter int unsigned CountWidth = dwc_pkg::CountWidthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dwc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dwc_pkg::out_t out_data_o
);

  localparam int unsigned ClassW = dwc_pkg::ClassW;
  localparam int unsigned ExtW   = (CountWidth > dwc_pkg::OutCountW) ?
                                   CountWidth : dwc_pkg::OutCountW;

  logic module_kind_q;

  dwc_pkg::pend_e          pend_q, pend_d;
  logic [ClassW-1:0]       pcls_q, pcls_d;
  logic [dwc_pkg::WinW-1:0] rem_q, rem_d;
  logic [ClassW-1:0]       cls;
  dwc_pkg::tab_ent_t       ent;
  logic [dwc_pkg::WinW:0]  width_p1;
  logic                    top_bit;

  logic                    in_xfer;
  logic                    s1_vld_q;
  logic [ClassW-1:0]       s1_cls_q;
  logic                    s1_fwd_q;
  logic [CountWidth-1:0]   s1_fwd_val_q;
  logic                    s1_ent_vld_q;
  logic                    s1_adv;
  logic [CountWidth-1:0]   rdata;
  logic [CountWidth-1:0]   cur_val;
  logic [CountWidth-1:0]   new_val;
  logic [dwc_pkg::NumClasses-1:0] ent_vld_q;
  logic [ExtW-1:0]         new_ext;

  logic                    out_vld_q;
  dwc_pkg::out_t           out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      module_kind_q <= 1'b0;
    end else if (cfg_we_i) begin
      module_kind_q <= cfg_wdata_i;
    end
  end

  // Decode against pending continuation state
  always_comb begin
    top_bit  = in_data_i.data_word[31];
    pend_d   = pend_q;
    pcls_d   = pcls_q;
    rem_d    = rem_q;
    cls      = dwc_pkg::ClsUnknown;
    ent      = dwc_pkg::type_lookup(module_kind_q, in_data_i.data_word[30:27]);
    width_p1 = {1'b0, in_data_i.data_word[dwc_pkg::WinW-1:0]} + 1'b1;
    if (pend_q == dwc_pkg::PendWindow) begin
      cls = dwc_pkg::ClsWindowRaw;
      if (rem_q != '0) begin
        rem_d = rem_q - 1'b1;
      end
      if (rem_d == '0) begin
        pend_d = dwc_pkg::PendNone;
      end
    end else if ((pend_q == dwc_pkg::PendOne || pend_q == dwc_pkg::PendPulse)
                 && !top_bit) begin
      cls = pcls_q;
      if (pend_q == dwc_pkg::PendOne) begin
        pend_d = dwc_pkg::PendNone;
      end
    end else begin
      pend_d = dwc_pkg::PendNone;
      if (top_bit) begin
        cls    = ent.cls;
        pend_d = ent.pend;
        pcls_d = ent.cls;
        if (ent.cls == dwc_pkg::ClsWindowRaw) begin
          rem_d  = width_p1[dwc_pkg::WinW:1];
          pend_d = (rem_d != '0) ? dwc_pkg::PendWindow : dwc_pkg::PendNone;
        end
      end
    end
    if (in_data_i.bank_end) begin
      pend_d = dwc_pkg::PendNone;
      rem_d  = '0;
    end
  end

  assign s1_adv     = s1_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = s1_vld_q && !s1_adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= dwc_pkg::PendNone;
      pcls_q <= '0;
      rem_q  <= '0;
    end else if (in_xfer) begin
      pend_q <= pend_d;
      pcls_q <= pcls_d;
      rem_q  <= rem_d;
    end
  end

  dwc_ram #(
    .Width (CountWidth),
    .Depth (dwc_pkg::NumClasses)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_cls_q),
    .wdata_i (new_val),
    .re_i    (in_xfer),
    .raddr_i (cls),
    .rdata_o (rdata)
  );

  // Forward a write that lands on the same edge as the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q     <= 1'b0;
      s1_fwd_q     <= 1'b0;
      s1_ent_vld_q <= 1'b0;
      s1_cls_q     <= '0;
    end else begin
      if (in_xfer) begin
        s1_vld_q     <= 1'b1;
        s1_cls_q     <= cls;
        s1_fwd_q     <= s1_adv && (s1_cls_q == cls);
        s1_ent_vld_q <= ent_vld_q[cls];
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_fwd_val_q <= new_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
    end else if (s1_adv) begin
      ent_vld_q[s1_cls_q] <= 1'b1;
    end
  end

  always_comb begin
    if (s1_fwd_q) begin
      cur_val = s1_fwd_val_q;
    end else if (s1_ent_vld_q) begin
      cur_val = rdata;
    end else begin
      cur_val = '0;
    end
    new_val = (cur_val == '1) ? cur_val : cur_val + 1'b1;
    new_ext = ExtW'(new_val);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.word_class  <= s1_cls_q;
      out_q.class_count <= new_ext[dwc_pkg::OutCountW-1:0];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
